@@ rtl/cisdw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cisdw_pkg;

  localparam int DIST_W   = 32;
  localparam int WEIGHT_W = 18;
  localparam int CFG_IDX_W = 2;

  // Search variable wm = weight - 1, one bit decided per pipeline stage.
  localparam int WM_BITS = 18;
  // Running product a^2*d and a*d never exceed 2^50 once accepted.
  localparam int PROD_W  = 51;
  // Trial sum before the compare: a*d shifted up by at most WM_BITS+1.
  localparam int TRIAL_W = 72;

  localparam logic [TRIAL_W-1:0]  PROD_LIMIT    = TRIAL_W'(1) << 50;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = '1;
  localparam logic [DIST_W-1:0]   CUTOFF_RESET  = 32'hFFFF_FFFF;
  localparam logic [DIST_W-1:0]   MIN_DIST_RESET = 32'd6553;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd1;

  typedef struct packed {
    logic                 valid;
    logic                 in_win;
    logic                 last;
    logic [DIST_W-1:0]    dst;
    logic [PROD_W-1:0]    p;
    logic [PROD_W-1:0]    q;
    logic [WM_BITS-1:0]   wm;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/cisdw_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cisdw_window (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [cisdw_pkg::DIST_W-1:0]  distance,
  input  wire logic                          is_last,
  input  wire logic [cisdw_pkg::DIST_W-1:0]  cutoff,
  input  wire logic [cisdw_pkg::DIST_W-1:0]  min_distance,
  output cisdw_pkg::stage_t                  stage_out
);

  cisdw_pkg::stage_t stage_r;
  cisdw_pkg::stage_t stage_nxt;

  // The search starts from a = 1, so both products equal the distance.
  always_comb begin
    stage_nxt        = stage_r;
    stage_nxt.valid  = in_valid;
    stage_nxt.in_win = (distance < cutoff) && (distance > min_distance);
    stage_nxt.last   = is_last;
    stage_nxt.dst    = distance;
    stage_nxt.p      = cisdw_pkg::PROD_W'(distance);
    stage_nxt.q      = cisdw_pkg::PROD_W'(distance);
    stage_nxt.wm     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

@@ rtl/cisdw_isqrt_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial search for the largest wm with (2*wm+1)^2 * d <= 2^50.
// With a = 2*wm+1, setting bit k of wm adds 2^(k+1) to a, so
//   a'^2*d = a^2*d + (a*d << (k+2)) + (d << (2k+2))
//   a'*d   = a*d + (d << (k+1))
// and each stage needs only shifted adds and one compare.
module cisdw_isqrt_pipe (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire cisdw_pkg::stage_t stage_in,
  output cisdw_pkg::stage_t stage_out
);

  cisdw_pkg::stage_t stg_r [cisdw_pkg::WM_BITS+1];

  assign stg_r[0] = stage_in;

  for (genvar j = 0; j < cisdw_pkg::WM_BITS; j++) begin : g_bit
    localparam int K = cisdw_pkg::WM_BITS - 1 - j;

    cisdw_pkg::stage_t               nxt;
    logic [cisdw_pkg::TRIAL_W-1:0]   trial;
    logic [cisdw_pkg::TRIAL_W-1:0]   q_up;
    logic                            take;

    always_comb begin
      trial = cisdw_pkg::TRIAL_W'(stg_r[j].p)
            + (cisdw_pkg::TRIAL_W'(stg_r[j].q) << (K + 2))
            + (cisdw_pkg::TRIAL_W'(stg_r[j].dst) << (2 * K + 2));
      q_up  = cisdw_pkg::TRIAL_W'(stg_r[j].q)
            + (cisdw_pkg::TRIAL_W'(stg_r[j].dst) << (K + 1));
      take  = (trial <= cisdw_pkg::PROD_LIMIT);
      nxt   = stg_r[j];
      if (take) begin
        nxt.p     = trial[cisdw_pkg::PROD_W-1:0];
        nxt.q     = q_up[cisdw_pkg::PROD_W-1:0];
        nxt.wm[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[j+1] <= '0;
      end else if (en) begin
        stg_r[j+1] <= nxt;
      end
    end
  end

  assign stage_out = stg_r[cisdw_pkg::WM_BITS];

endmodule

`default_nettype wire

@@ rtl/cutoff_inverse_sqrt_distance_weight_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Thresholded inverse square root of a stream of Q16.16 distances.
// Input channel (in_valid/in_ready) takes one word per cycle: a distance and
// a last-element mark. Output channel (out_valid/out_ready) returns one word
// per input word, in order: weight = round(2^24/sqrt(distance)) as Q2.16,
// saturated at the field maximum, when min_distance < distance < cutoff,
// otherwise zero with out_in_window low. The mark is copied to ends_matrix.
// From acceptance to out_valid a word passes one window stage, eighteen
// search stages (one weight bit each, set by a 72-bit add and compare) and
// one output register. Throughput is one word per cycle unless stalled.
// The whole pipeline advances as one unit; when the receiver stalls with a
// word waiting, every stage holds and in_ready drops, so nothing is lost or
// repeated. Bubbles move forward whenever the output register is free.
// Configuration is a plain write port: cfg_index 0 is cutoff, 1 is
// min_distance, other indexes are ignored. Write only while the pipeline is
// empty. Synchronous reset empties the pipeline and restores cutoff to all
// ones and min_distance to 6553 (0.1).
module cutoff_inverse_sqrt_distance_weight_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [cisdw_pkg::DIST_W-1:0]     in_distance,
  input  wire logic                             in_is_last,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [cisdw_pkg::WEIGHT_W-1:0]   out_weight,
  output      logic                             out_in_window,
  output      logic                             out_ends_matrix,
  input  wire logic                             cfg_we,
  input  wire logic [cisdw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cisdw_pkg::DIST_W-1:0]     cfg_wdata
);

  logic [cisdw_pkg::DIST_W-1:0] cutoff_r;
  logic [cisdw_pkg::DIST_W-1:0] min_dist_r;

  // Register writes; unknown indexes fall through the default arm.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r   <= cisdw_pkg::CUTOFF_RESET;
      min_dist_r <= cisdw_pkg::MIN_DIST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cisdw_pkg::CFG_CUTOFF:   cutoff_r   <= cfg_wdata;
        cisdw_pkg::CFG_MIN_DIST: min_dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being drained.
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  cisdw_pkg::stage_t win_stage;
  cisdw_pkg::stage_t srch_stage;

  cisdw_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .in_valid     (in_valid),
    .distance     (in_distance),
    .is_last      (in_is_last),
    .cutoff       (cutoff_r),
    .min_distance (min_dist_r),
    .stage_out    (win_stage)
  );

  cisdw_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .stage_in  (win_stage),
    .stage_out (srch_stage)
  );

  // The search yields weight - 1; adding one reaches 2^18 only when the
  // true weight is past the field, which saturates.
  logic                           out_valid_r;
  logic [cisdw_pkg::WEIGHT_W-1:0] weight_r;
  logic [cisdw_pkg::WEIGHT_W-1:0] weight_nxt;
  logic                           in_window_r;
  logic                           ends_matrix_r;

  always_comb begin
    if (!srch_stage.in_win) begin
      weight_nxt = '0;
    end else if (srch_stage.wm == cisdw_pkg::WEIGHT_MAX) begin
      weight_nxt = cisdw_pkg::WEIGHT_MAX;
    end else begin
      weight_nxt = cisdw_pkg::WEIGHT_W'(srch_stage.wm) + cisdw_pkg::WEIGHT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= srch_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      weight_r      <= weight_nxt;
      in_window_r   <= srch_stage.in_win;
      ends_matrix_r <= srch_stage.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_weight      = weight_r;
  assign out_in_window   = in_window_r;
  assign out_ends_matrix = ends_matrix_r;

`ifndef SYNTHESIS
  // A word outside the window carries a zero weight.
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_window |-> out_weight == '0)
    else $error("nonzero weight outside the window");

  // A word inside the window always carries a weight of at least one.
  a_nonzero_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_window |-> out_weight != '0)
    else $error("zero weight inside the window");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the thresholded inverse square root core. Every accepted
// input word is turned into its expected output word by a small predictor
// held in the scoreboard class, and every accepted output word is compared
// field by field with the oldest expectation. The stimulus starts with a few
// directed windows and distances, then runs several random windows, most
// with random idling on both channels, and ends with a phase that never idles.
module tb_top;
  import cisdw_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 10;
  // Acceptance to out_valid, through the window, search and output registers.
  localparam int PIPE_LATENCY    = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 200;
  // The slowest correct run is about 1700 words, each waiting out the longest
  // sender gap and the longest receiver stall, plus one pipeline drain per
  // phase. The limit is ten times a generous bound on that.
  localparam int CYCLE_LIMIT     = 300000;

  // Register indexes that the core does not implement; writes must vanish.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [WEIGHT_W-1:0] weight;
    logic                in_window;
    logic                ends_matrix;
  } weight_word_t;

  // The scoreboard keeps its own copy of the two window registers and a
  // queue of expected output words in acceptance order.
  class weight_scoreboard;
    logic [DIST_W-1:0] cutoff;
    logic [DIST_W-1:0] min_dist;
    weight_word_t      expected_q[$];
    int unsigned       errors;

    function new();
      cutoff   = CUTOFF_RESET;
      min_dist = MIN_DIST_RESET;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
      if (idx == CFG_CUTOFF) begin
        cutoff = val;
      end else if (idx == CFG_MIN_DIST) begin
        min_dist = val;
      end
    endfunction

    // The weight is the largest w with (2w-1)^2 <= floor(2^50/d), which is
    // 2^24/sqrt(d) rounded half up. With r = isqrt(floor(2^50/d)) that is
    // (r+1)/2, clamped to the field maximum.
    static function logic [WEIGHT_W-1:0] inv_sqrt_weight(logic [DIST_W-1:0] d);
      longint unsigned quotient;
      longint unsigned root;
      longint unsigned trial;
      longint unsigned w;
      quotient = (64'd1 << 50) / {32'd0, d};
      root = 0;
      for (int b = 25; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= quotient) root = trial;
      end
      w = (root + 1) >> 1;
      if (w > {46'd0, WEIGHT_MAX}) w = {46'd0, WEIGHT_MAX};
      return w[WEIGHT_W-1:0];
    endfunction

    function void note_input(logic [DIST_W-1:0] d, logic last);
      weight_word_t exp_word;
      exp_word.distance    = d;
      exp_word.in_window   = (d < cutoff) && (d > min_dist);
      exp_word.weight      = exp_word.in_window ? inv_sqrt_weight(d) : '0;
      exp_word.ends_matrix = last;
      expected_q.push_back(exp_word);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [WEIGHT_W-1:0] weight, logic in_window, logic ends_matrix);
      weight_word_t exp_word;
      if (expected_q.size() == 0) begin
        report("output word with no expected word waiting");
      end else begin
        exp_word = expected_q.pop_front();
        if (weight !== exp_word.weight)
          report($sformatf("distance %h: weight %0d, expected %0d",
                           exp_word.distance, weight, exp_word.weight));
        if (in_window !== exp_word.in_window)
          report($sformatf("distance %h: in_window %b, expected %b",
                           exp_word.distance, in_window, exp_word.in_window));
        if (ends_matrix !== exp_word.ends_matrix)
          report($sformatf("distance %h: ends_matrix %b, expected %b",
                           exp_word.distance, ends_matrix, exp_word.ends_matrix));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DIST_W-1:0]    in_distance = '0;
  logic                 in_is_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WEIGHT_W-1:0]  out_weight;
  logic                 out_in_window;
  logic                 out_ends_matrix;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0]    cfg_wdata = '0;

  weight_scoreboard sb = new();

  // Window currently programmed; the random distance picker aims at it.
  logic [DIST_W-1:0] cur_cutoff = CUTOFF_RESET;
  logic [DIST_W-1:0] cur_min = MIN_DIST_RESET;

  // The sender flag is only read by the main thread, so it is set with
  // blocking assignments; the receiver flag is read by the ready process at
  // the clock edge and therefore changes only through nonblocking writes.
  bit          tx_idle_en = 1'b1;
  bit          rx_stall_en = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  cutoff_inverse_sqrt_distance_weight_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_distance     (in_distance),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_weight      (out_weight),
    .out_in_window   (out_in_window),
    .out_ends_matrix (out_ends_matrix),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // The receiver drops ready in random bursts when stalling is
  // enabled, and otherwise keeps it high.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 6) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Both channels are sampled at the clock edge, before any nonblocking
  // update of that edge lands, so every word is seen exactly once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_distance, in_is_last);
      if (out_valid && out_ready) sb.check_result(out_weight, out_in_window, out_ends_matrix);
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, sb.expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one word, possibly after a random gap, and returns at the edge
  // that accepts it. Valid stays high from offer to acceptance.
  task automatic send_word(input logic [DIST_W-1:0] d, input logic last);
    int unsigned gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_distance <= d;
    in_is_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender back until every expected word has come out, so the
  // pipeline is empty and the window registers may change.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Writes both window registers, and now and then a spare index that the
  // core has to ignore. Only called with the pipeline empty.
  task automatic program_window(input logic [DIST_W-1:0] cut, input logic [DIST_W-1:0] mn);
    logic [CFG_IDX_W-1:0] spare;
    logic [DIST_W-1:0]    junk;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CUTOFF;
    cfg_wdata <= cut;
    @(posedge clk);
    sb.write_reg(CFG_CUTOFF, cut);
    cfg_index <= CFG_MIN_DIST;
    cfg_wdata <= mn;
    @(posedge clk);
    sb.write_reg(CFG_MIN_DIST, mn);
    if ($urandom_range(0, 1) == 1) begin
      spare = $urandom_range(0, 1) == 1 ? CFG_SPARE_A : CFG_SPARE_B;
      junk  = $urandom;
      cfg_index <= spare;
      cfg_wdata <= junk;
      @(posedge clk);
      sb.write_reg(spare, junk);
    end
    cfg_we <= 1'b0;
    cur_cutoff = cut;
    cur_min    = mn;
  endtask

  // Random distances lean toward the open window and the values around its thresholds, with
  // small values for saturation and some fully random and extreme values.
  function automatic logic [DIST_W-1:0] pick_distance();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50 && {1'b0, cur_cutoff} > {1'b0, cur_min} + 33'd1)
      return $urandom_range(cur_min + 1, cur_cutoff - 1);
    if (sel < 65)
      return (sel[0] ? cur_min : cur_cutoff) + DIST_W'($urandom_range(0, 4)) - DIST_W'(2);
    if (sel < 75)
      return $urandom_range(0, 8192);
    if (sel < 95)
      return $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return DIST_W'(1);
      2:       return 32'hFFFF_FFFE;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin
    logic [DIST_W-1:0] cut;
    logic [DIST_W-1:0] mn;
    bit                calm;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n       <= 1'b1;
    rx_stall_en <= 1'b1;
    @(posedge clk);

    // Window left at its reset values: zero, both edges of 0.1, exactly 1.0
    // (weight 65536), and the top of the range, where the cutoff itself is.
    send_word(32'd0, 1'b0);
    send_word(32'd6553, 1'b1);
    send_word(32'd6554, 1'b0);
    send_word(32'h0001_0000, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    drain();

    // Zero minimum distance: zero stays out, one and other tiny distances
    // saturate, and the weight drops below the maximum just above 4096.
    program_window(32'hFFFF_FFFF, 32'd0);
    send_word(32'd0, 1'b0);
    send_word(32'd1, 1'b0);
    send_word(32'd2, 1'b1);
    send_word(32'd4096, 1'b0);
    send_word(32'd4097, 1'b0);
    send_word(32'h5555_AAAA, 1'b1);
    send_word(32'hFFFF_FFFE, 1'b0);
    drain();

    // Empty windows: nothing lies strictly between the thresholds.
    program_window(32'd1000, 32'd999);
    send_word(32'd999, 1'b0);
    send_word(32'd1000, 1'b1);
    send_word(32'd1001, 1'b0);
    drain();
    program_window(32'd0, 32'hFFFF_FFFF);
    send_word(32'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    drain();

    // Narrowest open window: a single distance is inside.
    program_window(32'd1001, 32'd999);
    send_word(32'd1000, 1'b1);
    send_word(32'd1001, 1'b0);

    // Random phases, each with its own window. The first one opens the
    // window as wide as it goes; the last one runs without any idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      if (phase == 0) begin
        cut = 32'hFFFF_FFFF;
        mn  = '0;
      end else begin
        mn  = $urandom_range(0, 1) == 1 ? DIST_W'($urandom_range(0, 8192)) : DIST_W'($urandom);
        cut = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : mn + DIST_W'($urandom);
      end
      program_window(cut, mn);
      calm = (phase == RANDOM_PHASES - 1) || ($urandom_range(0, 5) == 0);
      tx_idle_en  = !calm;
      rx_stall_en <= !calm;
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        send_word(pick_distance(), $urandom_range(0, 15) == 0);
    end

    drain();
    // Give a stray extra word time to show up after the last expected one.
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
